>>> sv/oqr_pkg.sv
package oqr_pkg;

   localparam int ID_W          = 16;
   localparam int STATUS_W      = 2;
   localparam int DEPTH_DEFAULT = 64;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_DUMP   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_APPEND = 2'd1,
      OP_REMOVE = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DUMP = 1'b1
   } state_type;

   typedef struct packed {
      cell_op_type     op;
      logic [ID_W-1:0] ident;
   } cell_ctrl_type;

endpackage

>>> sv/oqr_cell.sv
module oqr_cell
   import oqr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cell_ctrl_type   ctrl,
   input  logic [ID_W-1:0] head,
   input  logic            prev_valid,
   input  logic            next_valid,
   input  logic [ID_W-1:0] next_data,
   input  logic            hit_in,
   output logic            hit_out,
   output logic            valid,
   output logic [ID_W-1:0] data
);

   logic            valid_ff, valid_in;
   logic [ID_W-1:0] data_ff, data_in;

   // hit_out is high from the first matching cell onward
   assign hit_out = hit_in | (valid_ff && data_ff == ctrl.ident);
   assign valid   = valid_ff;
   assign data    = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (ctrl.op)
         OP_APPEND: begin
            if (!valid_ff && prev_valid) begin
               valid_in = 1'b1;
               data_in  = ctrl.ident;
            end
         end
         OP_REMOVE: begin
            if (hit_out) begin
               valid_in = next_valid;
               data_in  = next_data;
            end
         end
         OP_ROTATE: begin
            // tail cell takes the head, the others take their neighbor
            if (valid_ff) begin
               data_in = next_valid ? next_data : head;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> sv/oqr_ctrl.sv
module oqr_ctrl
   import oqr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [ID_W-1:0]     req_ident,
   input  logic                full,
   input  logic                found,
   input  logic [ID_W-1:0]     head,
   output cell_ctrl_type       ctrl,
   output logic                rsp_strobe,
   output logic [ID_W-1:0]     rsp_entry,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            strobe_ff, strobe_in;
   logic [ID_W-1:0] entry_ff, entry_in;
   status_type      status_ff, status_in;
   logic            last_ff, last_in;
   cmd_type         cmd;

   assign cmd        = cmd_type'(req_command);
   assign busy       = (state_ff == ST_DUMP);
   assign rsp_strobe = strobe_ff;
   assign rsp_entry  = entry_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      strobe_in  = 1'b0;
      entry_in   = req_ident;
      status_in  = STAT_OK;
      last_in    = 1'b1;
      ctrl.op    = OP_HOLD;
      ctrl.ident = req_ident;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (cmd)
                  CMD_APPEND: begin
                     ctrl.op   = OP_APPEND;
                     strobe_in = 1'b1;
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     ctrl.op   = OP_REMOVE;
                     strobe_in = 1'b1;
                     if (found) begin
                        fill_in = fill_ff - CNT_W'(1);
                     end else begin
                        status_in = STAT_NOT_FOUND;
                     end
                  end
                  CMD_DUMP: begin
                     if (fill_ff == '0) begin
                        strobe_in = 1'b1;
                        entry_in  = '0;
                        status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_DUMP;
                        count_in = fill_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DUMP: begin
            // emit head and rotate; after fill steps the order is restored
            ctrl.op   = OP_ROTATE;
            strobe_in = 1'b1;
            entry_in  = head;
            last_in   = (count_ff == CNT_W'(1));
            count_in  = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

endmodule

>>> sv/ordered_queue_remove_by_value_unit.sv
// Channel   Ports                                        Handshake
// request   start, busy, req_command, req_ident          taken when start && !busy
// response  rsp_strobe, rsp_entry, rsp_status, rsp_last  one cycle per strobe, no stall
//
// Append and remove update the cell row in the cycle they are taken; the
// response shows in the next cycle and a new request may follow at once.
// A dump of a non-empty queue keeps busy high while the row rotates one place
// a cycle and the head cell streams out, until every entry has been sent once.
// Synchronous reset empties the queue; the response side cannot stall.
module ordered_queue_remove_by_value_unit
   import oqr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [ID_W-1:0]     req_ident,
   output logic                rsp_strobe,
   output logic [ID_W-1:0]     rsp_entry,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   cell_ctrl_type   ctrl;
   logic            valid_w [DEPTH];
   logic [ID_W-1:0] data_w  [DEPTH];
   logic            hit_w   [DEPTH+1];

   assign hit_w[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic            prev_valid;
      logic            next_valid;
      logic [ID_W-1:0] next_data;

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_mid
         assign prev_valid = valid_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign next_valid = 1'b0;
         assign next_data  = data_w[i];
      end else begin : g_inner
         assign next_valid = valid_w[i+1];
         assign next_data  = data_w[i+1];
      end

      oqr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .head       (data_w[0]),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .next_data  (next_data),
         .hit_in     (hit_w[i]),
         .hit_out    (hit_w[i+1]),
         .valid      (valid_w[i]),
         .data       (data_w[i])
      );
   end

   oqr_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_ident   (req_ident),
      .full        (valid_w[DEPTH-1]),
      .found       (hit_w[DEPTH]),
      .head        (data_w[0]),
      .ctrl        (ctrl),
      .rsp_strobe  (rsp_strobe),
      .rsp_entry   (rsp_entry),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

endmodule

>>> verif/ordered_queue_remove_by_value_checker.sv
`timescale 1ns / 100ps

module ordered_queue_remove_by_value_checker
   import oqr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [1:0]          req_command,
   input  logic [ID_W-1:0]     req_ident,
   input  logic                rsp_strobe,
   input  logic [ID_W-1:0]     rsp_entry,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic                rsp_last,
   output int                  fail_count,
   output int                  pending
);

   typedef struct packed {
      logic [ID_W-1:0] entry;
      status_type      status;
      logic            last;
   } queue_reply_type;

   // predicted queue contents, head first
   logic [ID_W-1:0] queued_ids[$];
   queue_reply_type expected_replies[$];

   task automatic apply_command(input cmd_type cmd, input logic [ID_W-1:0] ident);
      int hit;
      int i;
      hit = -1;
      case (cmd)
         CMD_APPEND: begin
            if (queued_ids.size() >= DEPTH) begin
               expected_replies.push_back('{ident, STAT_FULL, 1'b1});
            end else begin
               queued_ids.push_back(ident);
               expected_replies.push_back('{ident, STAT_OK, 1'b1});
            end
         end
         CMD_REMOVE: begin
            for (i = 0; i < queued_ids.size(); i++) begin
               if (hit < 0 && queued_ids[i] == ident) hit = i;
            end
            if (hit < 0) begin
               expected_replies.push_back('{ident, STAT_NOT_FOUND, 1'b1});
            end else begin
               queued_ids.delete(hit);
               expected_replies.push_back('{ident, STAT_OK, 1'b1});
            end
         end
         CMD_DUMP: begin
            if (queued_ids.size() == 0) begin
               expected_replies.push_back('{'0, STAT_EMPTY, 1'b1});
            end else begin
               for (i = 0; i < queued_ids.size(); i++) begin
                  expected_replies.push_back('{queued_ids[i], STAT_OK,
                                               i == queued_ids.size() - 1});
               end
            end
         end
         default: ;  // unused code: no response, no state change
      endcase
   endtask

   task automatic match_reply();
      queue_reply_type want;
      if (expected_replies.size() == 0) begin
         $error("unexpected response: entry %h status %0d last %0d",
                rsp_entry, rsp_status, rsp_last);
         fail_count++;
      end else begin
         want = expected_replies.pop_front();
         if (rsp_entry !== want.entry) begin
            $error("rsp_entry: expected %h, actual %h", want.entry, rsp_entry);
            fail_count++;
         end
         if (rsp_status !== want.status) begin
            $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
            fail_count++;
         end
         if (rsp_last !== want.last) begin
            $error("rsp_last: expected %0d, actual %0d", want.last, rsp_last);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         queued_ids.delete();
         expected_replies.delete();
         fail_count = 0;
         pending <= 0;
      end else begin
         // a response seen here always belongs to an earlier request
         if (rsp_strobe) match_reply();
         if (start && !busy) apply_command(cmd_type'(req_command), req_ident);
         pending <= expected_replies.size();
      end
   end

endmodule

>>> verif/ordered_queue_remove_by_value_unit_tb.sv
`timescale 1ns / 100ps

module ordered_queue_remove_by_value_unit_tb;
   import oqr_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic [1:0]          req_command = CMD_APPEND;
   logic [ID_W-1:0]     req_ident   = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [ID_W-1:0]     rsp_entry;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;
   int                  fail_count;
   int                  pending;

   int                  burst_left = 0;
   logic [ID_W-1:0]     id_pool[16];

   always #1 clock = ~clock;

   ordered_queue_remove_by_value_unit #(.DEPTH(DEPTH)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_ident   (req_ident),
      .rsp_strobe  (rsp_strobe),
      .rsp_entry   (rsp_entry),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

   ordered_queue_remove_by_value_checker #(.DEPTH(DEPTH)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_ident   (req_ident),
      .rsp_strobe  (rsp_strobe),
      .rsp_entry   (rsp_entry),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // one request; idles between bursts, holds start while busy
   task automatic send_request(input cmd_type cmd, input logic [ID_W-1:0] ident);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_ident   <= ident;
      do @(posedge clock); while (busy);
      burst_left--;
   endtask

   // mostly a small pool so removes hit and duplicates appear
   function automatic logic [ID_W-1:0] pick_ident();
      if ($urandom_range(0, 99) < 70) return id_pool[$urandom_range(0, 15)];
      return ID_W'($urandom_range(0, 65535));
   endfunction

   task automatic run_mix(input int count, input int pct_append, input int pct_remove);
      int sent;
      int roll;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 3) begin
            send_request(CMD_NONE, pick_ident());
         end else begin
            if (roll < pct_append) send_request(CMD_APPEND, pick_ident());
            else if (roll < pct_append + pct_remove) send_request(CMD_REMOVE, pick_ident());
            else send_request(CMD_DUMP, pick_ident());
            sent++;
         end
      end
   endtask

   initial begin
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < 16; i++) id_pool[i] = ID_W'($urandom_range(0, 65535));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty queue cases
      send_request(CMD_DUMP,   16'hFFFF);
      send_request(CMD_REMOVE, 16'h0000);
      // extremes, duplicate value
      send_request(CMD_APPEND, 16'h0000);
      send_request(CMD_APPEND, 16'hFFFF);
      send_request(CMD_APPEND, 16'h1234);
      send_request(CMD_APPEND, 16'hFFFF);
      send_request(CMD_APPEND, 16'h8000);
      send_request(CMD_DUMP,   16'h5555);
      // first of two equal entries, from the middle
      send_request(CMD_REMOVE, 16'hFFFF);
      send_request(CMD_DUMP,   16'h0000);
      send_request(CMD_REMOVE, 16'h8000);
      send_request(CMD_REMOVE, 16'h0000);
      send_request(CMD_REMOVE, 16'h4321);
      send_request(CMD_NONE,   16'hAAAA);
      send_request(CMD_DUMP,   16'h0000);
      send_request(CMD_REMOVE, 16'h1234);
      send_request(CMD_REMOVE, 16'hFFFF);
      send_request(CMD_REMOVE, 16'hFFFF);
      send_request(CMD_DUMP,   16'h0000);

      // fill past full so appends get dropped, then drain and mix
      run_mix(75, 100, 0);
      send_request(CMD_DUMP, pick_ident());
      run_mix(60, 10, 80);
      run_mix(50, 40, 40);
      run_mix(60, 75, 15);
      run_mix(60, 15, 75);

      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
